// File: design/khbi_pkg.sv
// khbi_pkg: shared widths, constants and hash functions for the key hash block
// no dependencies; used by the interfaces and every module of the block

package khbi_pkg;

   localparam int KEY_W   = 8;
   localparam int HASH_W  = 32;
   localparam int INDEX_W = 31;
   localparam int TSL_W   = 5;
   localparam int PRE_W   = HASH_W - 3;

   localparam logic [HASH_W-1:0] CRC_POLY  = 32'h82F63B78;
   localparam logic [HASH_W-1:0] CRC_INIT  = 32'h00000000;
   localparam logic [HASH_W-1:0] MIX_MULT  = 32'd2654435761;
   localparam logic [TSL_W-1:0]  TSL_RESET = 5'd4;

   // final crc of a key on its way to the mix pipeline
   typedef struct packed {
      logic              valid;
      logic [HASH_W-1:0] crc;
   } fin_type;

   // reflected crc-32c update by one byte
   function automatic logic [HASH_W-1:0] crc_byte(input logic [HASH_W-1:0] crc,
                                                  input logic [KEY_W-1:0]  data);
      logic [HASH_W-1:0] c;
      c = crc ^ {{(HASH_W-KEY_W){1'b0}}, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // mix steps one and two
   function automatic logic [HASH_W-1:0] mix_ab(input logic [HASH_W-1:0] v);
      logic [HASH_W-1:0] t;
      t = v + (v << 12);
      return t ^ (t >> 22);
   endfunction

   // mix steps three and four
   function automatic logic [HASH_W-1:0] mix_cd(input logic [HASH_W-1:0] v);
      logic [HASH_W-1:0] t;
      t = v + (v << 4);
      return t ^ (t >> 9);
   endfunction

   // mix steps five and six
   function automatic logic [HASH_W-1:0] mix_ef(input logic [HASH_W-1:0] v);
      logic [HASH_W-1:0] t;
      t = v + (v << 10);
      return t ^ (t >> 2);
   endfunction

   // mix steps seven and eight
   function automatic logic [HASH_W-1:0] mix_gh(input logic [HASH_W-1:0] v);
      logic [HASH_W-1:0] t;
      t = v + (v << 7);
      return t ^ (t >> 12);
   endfunction

   // low n bits set, n from 0 to 31
   function automatic logic [INDEX_W-1:0] bucket_mask(input logic [TSL_W-1:0] n);
      logic [INDEX_W-1:0] m;
      for (int i = 0; i < INDEX_W; i++) begin
         m[i] = (TSL_W'(i) < n);
      end
      return m;
   endfunction

endpackage

// File: design/khbi_if.sv
// khbi_if: valid/ready channel interfaces for key bytes and hash results
// depends on khbi_pkg for field widths

interface khbi_req_if import khbi_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] key_byte;
   logic             has_byte;
   logic             last;

   modport source (output valid, key_byte, has_byte, last, input ready);
   modport sink   (input valid, key_byte, has_byte, last, output ready);
endinterface

interface khbi_rsp_if import khbi_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [HASH_W-1:0]  hash_value;
   logic [INDEX_W-1:0] bucket_index;

   modport source (output valid, hash_value, bucket_index, input ready);
   modport sink   (input valid, hash_value, bucket_index, output ready);
endinterface

// File: design/khbi_crc_acc.sv
// khbi_crc_acc: running crc-32c over key bytes, hands off the final crc per key
// depends on khbi_pkg and khbi_if

module khbi_crc_acc import khbi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   khbi_req_if.sink    req_ch,
   output fin_type     fin_o,
   input  logic        fin_ready
);

   logic [HASH_W-1:0] crc_ff, crc_in;
   logic              fin_valid_ff, fin_valid_in;
   logic [HASH_W-1:0] fin_crc_ff, fin_crc_in;
   logic [HASH_W-1:0] crc_upd;
   logic              acc;

   // take a byte whenever the handoff slot is free or draining
   assign req_ch.ready = !fin_valid_ff || fin_ready;
   assign acc          = req_ch.valid && req_ch.ready;

   // crc with this transaction's byte folded in
   assign crc_upd = req_ch.has_byte ? crc_byte(crc_ff, req_ch.key_byte) : crc_ff;

   // next state of crc and handoff slot
   always_comb begin
      crc_in       = crc_ff;
      fin_valid_in = fin_valid_ff;
      fin_crc_in   = fin_crc_ff;
      if (fin_ready) begin
         fin_valid_in = 1'b0;
      end
      if (acc) begin
         if (req_ch.last) begin
            crc_in       = CRC_INIT;
            fin_valid_in = 1'b1;
            fin_crc_in   = crc_upd;
         end else begin
            crc_in = crc_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         fin_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         fin_valid_ff <= fin_valid_in;
      end
      fin_crc_ff <= fin_crc_in;
   end

   assign fin_o = '{valid: fin_valid_ff, crc: fin_crc_ff};

   // crc restarts after the last byte of a key
   a_crc_clear: assert property (@(posedge clock) disable iff (reset)
      (acc && req_ch.last) |=> (crc_ff == CRC_INIT))
      else $error("crc not cleared after end of key");

   // a waiting final crc is not overwritten
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (fin_valid_ff && !fin_ready) |=> (fin_valid_ff && $stable(fin_crc_ff)))
      else $error("final crc lost while stalled");

endmodule

// File: design/khbi_mix_pipe.sv
// khbi_mix_pipe: pipelined 32-bit mix, multiply and bucket masking of a final crc
// depends on khbi_pkg and khbi_if

module khbi_mix_pipe import khbi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  fin_type          fin_i,
   output logic             fin_ready,
   input  logic [TSL_W-1:0] tsl,
   khbi_rsp_if.source       rsp_ch
);

   logic              a_vld_ff, a_vld_in, b_vld_ff, b_vld_in;
   logic              c_vld_ff, c_vld_in, d_vld_ff, d_vld_in;
   logic              h_vld_ff, h_vld_in;
   logic [HASH_W-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, h_ff, h_in;
   logic [PRE_W-1:0]  d_ff, d_in;
   logic              a_rdy, b_rdy, c_rdy, d_rdy, h_rdy;
   logic [HASH_W-1:0] gh_val;

   // per-stage ready, bubbles collapse
   assign h_rdy     = !h_vld_ff || rsp_ch.ready;
   assign d_rdy     = !d_vld_ff || h_rdy;
   assign c_rdy     = !c_vld_ff || d_rdy;
   assign b_rdy     = !b_vld_ff || c_rdy;
   assign a_rdy     = !a_vld_ff || b_rdy;
   assign fin_ready = a_rdy;

   assign gh_val = mix_gh(c_ff);

   // stage advance: a=steps 1-2, b=3-4, c=5-6, d=7-8 and shift, h=multiply
   always_comb begin
      a_vld_in = a_vld_ff; a_in = a_ff;
      b_vld_in = b_vld_ff; b_in = b_ff;
      c_vld_in = c_vld_ff; c_in = c_ff;
      d_vld_in = d_vld_ff; d_in = d_ff;
      h_vld_in = h_vld_ff; h_in = h_ff;
      if (a_rdy) begin
         a_vld_in = fin_i.valid;
         a_in     = mix_ab(fin_i.crc);
      end
      if (b_rdy) begin
         b_vld_in = a_vld_ff;
         b_in     = mix_cd(a_ff);
      end
      if (c_rdy) begin
         c_vld_in = b_vld_ff;
         c_in     = mix_ef(b_ff);
      end
      if (d_rdy) begin
         d_vld_in = c_vld_ff;
         d_in     = gh_val[HASH_W-1:3];
      end
      if (h_rdy) begin
         h_vld_in = d_vld_ff;
         h_in     = {3'b000, d_ff} * MIX_MULT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         h_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
         c_vld_ff <= c_vld_in;
         d_vld_ff <= d_vld_in;
         h_vld_ff <= h_vld_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      h_ff <= h_in;
   end

   // result channel; index masked by the table size register
   assign rsp_ch.valid        = h_vld_ff;
   assign rsp_ch.hash_value   = h_ff;
   assign rsp_ch.bucket_index = h_ff[INDEX_W-1:0] & bucket_mask(tsl);

   // a stalled stage keeps its contents
   a_b_hold: assert property (@(posedge clock) disable iff (reset)
      (b_vld_ff && !c_rdy) |=> (b_vld_ff && $stable(b_ff)))
      else $error("mix stage b overwritten while stalled");

   a_d_hold: assert property (@(posedge clock) disable iff (reset)
      (d_vld_ff && !h_rdy) |=> (d_vld_ff && $stable(d_ff)))
      else $error("mix stage d overwritten while stalled");

   // a new result only comes from a filled previous stage
   a_h_src: assert property (@(posedge clock) disable iff (reset)
      $rose(h_vld_ff) |-> $past(d_vld_ff))
      else $error("result appeared without a source");

endmodule

// File: design/key_hash_bucket_index.sv
// key_hash_bucket_index: top level, crc accumulator feeding the mix pipeline
// depends on khbi_pkg, khbi_if, khbi_crc_acc and khbi_mix_pipe
//
//   port        dir   transaction content
//   req_ch      in    key_byte[7:0], has_byte, last        (valid/ready)
//   rsp_ch      out   hash_value[31:0], bucket_index[30:0] (valid/ready)
//   csr_we/_wdata in  table_size_log2[4:0]                 (write only)
//
// One key byte is taken every cycle while the handoff slot is free or draining, and the crc
// register folds a byte per cycle while bytes are taken. The result of a key passes the
// handoff register, then four mix stages (the last one shifts) and the multiply register.
// Stalls on rsp_ch ripple back only through full stages; empty stages keep
// taking transactions. Synchronous reset clears the crc, all valid bits and
// sets table_size_log2 to 4.

module key_hash_bucket_index import khbi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   khbi_req_if.sink         req_ch,
   khbi_rsp_if.source       rsp_ch,
   input  logic             csr_we,
   input  logic [TSL_W-1:0] csr_wdata
);

   logic [TSL_W-1:0] tsl_ff, tsl_in;
   fin_type          fin;
   logic             fin_ready;

   // table size register
   assign tsl_in = csr_we ? csr_wdata : tsl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tsl_ff <= TSL_RESET;
      end else begin
         tsl_ff <= tsl_in;
      end
   end

   khbi_crc_acc u_crc_acc (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .fin_o     (fin),
      .fin_ready (fin_ready)
   );

   khbi_mix_pipe u_mix_pipe (
      .clock     (clock),
      .reset     (reset),
      .fin_i     (fin),
      .fin_ready (fin_ready),
      .tsl       (tsl_ff),
      .rsp_ch    (rsp_ch)
   );

endmodule

// File: bench/khbi_checker.sv
// khbi_checker: watches the key byte and hash result channels, predicts each hash
// and bucket index on its own and compares every result transaction in order
// depends on khbi_pkg and the channel interfaces of khbi_if

module khbi_checker import khbi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   khbi_req_if              req_mon,
   khbi_rsp_if              rsp_mon,
   input  logic             csr_we,
   input  logic [TSL_W-1:0] csr_wdata,
   output int               mismatch_count,
   output int               hashes_due
);

   localparam logic [31:0] CASTAGNOLI_POLY = 32'h82F63B78;
   localparam logic [31:0] GOLDEN_MULT     = 32'd2654435761;

   typedef struct packed {
      logic [HASH_W-1:0]  hash;
      logic [INDEX_W-1:0] index;
   } bucket_entry_type;

   bucket_entry_type   pending_hashes[$];
   logic [HASH_W-1:0]  key_crc    = '0;
   logic [TSL_W-1:0]   table_bits = 5'd4;
   int                 errs       = 0;

   // reflected crc-32c, one key bit at a time into the feedback
   function automatic logic [31:0] crc32c_fold(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ data[i];
         c  = (c >> 1) ^ (fb ? CASTAGNOLI_POLY : 32'h0);
      end
      return c;
   endfunction

   // eight shift/add/xor steps, then drop three bits and scale
   function automatic logic [31:0] scramble(input logic [31:0] seed);
      logic [31:0] v;
      v = seed;
      v = v + (v << 12);
      v = v ^ (v >> 22);
      v = v + (v << 4);
      v = v ^ (v >> 9);
      v = v + (v << 10);
      v = v ^ (v >> 2);
      v = v + (v << 7);
      v = v ^ (v >> 12);
      return (v >> 3) * GOLDEN_MULT;
   endfunction

   always @(posedge clock) begin : watch
      logic [31:0]      mask;
      bucket_entry_type want;
      if (reset) begin
         key_crc    = '0;
         table_bits = 5'd4;
         pending_hashes.delete();
      end else begin
         // key byte transaction: fold the byte, close the key on last
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            if (req_mon.has_byte)
               key_crc = crc32c_fold(key_crc, req_mon.key_byte);
            if (req_mon.last) begin
               want.hash  = scramble(key_crc);
               mask       = (32'd1 << table_bits) - 32'd1;
               want.index = want.hash[INDEX_W-1:0] & mask[INDEX_W-1:0];
               pending_hashes.push_back(want);
               key_crc = '0;
            end
         end

         // result transaction against the oldest prediction
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (pending_hashes.size() == 0) begin
               errs++;
               $display("%0t: unexpected result: expected none, got hash %h index %h",
                        $time, rsp_mon.hash_value, rsp_mon.bucket_index);
            end else begin
               want = pending_hashes.pop_front();
               if (rsp_mon.hash_value !== want.hash) begin
                  errs++;
                  $display("%0t: hash_value mismatch: expected %h, got %h",
                           $time, want.hash, rsp_mon.hash_value);
               end
               if (rsp_mon.bucket_index !== want.index) begin
                  errs++;
                  $display("%0t: bucket_index mismatch: expected %h, got %h",
                           $time, want.index, rsp_mon.bucket_index);
               end
            end
         end

         // table size takes effect after this edge
         if (csr_we)
            table_bits = csr_wdata;
      end
      mismatch_count <= errs;
      hashes_due     <= pending_hashes.size();
   end

endmodule

// File: bench/tb_key_hash_bucket_index.sv
// tb_key_hash_bucket_index: drives key bytes, table sizes and result back-pressure
// into key_hash_bucket_index; khbi_checker beside it predicts and compares
// depends on khbi_pkg, khbi_if, key_hash_bucket_index and khbi_checker

module tb_key_hash_bucket_index;
   import khbi_pkg::*;

   typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_COMB} rx_mode_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [TSL_W-1:0] csr_wdata;
   logic             hold_off = 1'b0;

   int  mismatch_count;
   int  hashes_due;
   int  items_sent  = 0;
   int  burst_left  = 8;
   int  phase_num   = 0;
   bit  gaps_on     = 1'b1;
   bit  offering    = 1'b0;

   khbi_req_if req_ch ();
   khbi_rsp_if rsp_ch ();

   key_hash_bucket_index uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   khbi_checker hash_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .hashes_due     (hashes_due)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #8000000;
      $display("Test completed with failures");
      $finish;
   end

   // one key byte transaction, then maybe a gap when the burst runs out
   task automatic offer_byte(input logic [7:0] b, input logic hb, input logic lst);
      int gap;
      req_ch.valid    <= 1'b1;
      req_ch.key_byte <= b;
      req_ch.has_byte <= hb;
      req_ch.last     <= lst;
      offering = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (hb || lst)
         items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // random key, sometimes closed by a byteless last, with idle noise inside
   task automatic send_key(input int nbytes);
      bit trailer;
      trailer = (nbytes == 0) || ($urandom_range(0, 7) == 0);
      for (int i = 0; i < nbytes; i++) begin
         if ($urandom_range(0, 11) == 0)
            offer_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         offer_byte(8'($urandom_range(0, 255)), 1'b1, !trailer && i == nbytes - 1);
      end
      if (trailer)
         offer_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // stop offering, wait for every hash, then let the pipeline go quiet
   task automatic drain_keys();
      if (offering) begin
         req_ch.valid <= 1'b0;
         offering = 1'b0;
      end
      do @(posedge clock); while (hashes_due != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_table_size(input logic [TSL_W-1:0] bits);
      csr_we    <= 1'b1;
      csr_wdata <= bits;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // result side: random back-pressure pattern, chosen anew when the current one runs out
   initial begin : receiver
      rx_mode_type mode;
      int          left;
      int          tick;
      bit          open;
      rsp_ch.ready = 1'b0;
      mode = RX_OPEN;
      left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = rx_mode_type'($urandom_range(0, 3));
            left = $urandom_range(20, 200);
         end
         left--;
         tick++;
         case (mode)
            RX_OPEN:   open = 1'b1;
            RX_HALF:   open = $urandom_range(0, 1) == 1;
            RX_SPARSE: open = $urandom_range(0, 3) == 0;
            default:   open = (tick % 4) != 3;
         endcase
         rsp_ch.ready <= open && !hold_off;
      end
   end

   // long result stall in the third phase so the pipeline backs up to the input
   initial begin : long_stall
      wait (phase_num == 3);
      repeat (30) @(posedge clock);
      hold_off <= 1'b1;
      repeat (400) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : stimulus
      logic [TSL_W-1:0] size_plan [7];
      int               goal;
      int               r;
      int               len;

      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      req_ch.valid    = 1'b0;
      req_ch.key_byte = '0;
      req_ch.has_byte = 1'b0;
      req_ch.last     = 1'b0;

      size_plan = '{5'd0, 5'd31, 5'd1, 5'd30, 5'd0, 5'd0, 5'd0};
      size_plan[4] = 5'($urandom_range(2, 29));
      size_plan[5] = 5'($urandom_range(0, 31));
      size_plan[6] = 5'($urandom_range(0, 31));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed keys under the reset table size
      offer_byte(8'h00, 1'b0, 1'b1);     // empty key
      offer_byte(8'hA5, 1'b0, 1'b0);     // idle, ignored
      offer_byte(8'h00, 1'b1, 1'b1);
      offer_byte(8'hFF, 1'b1, 1'b1);
      offer_byte(8'h55, 1'b1, 1'b1);
      offer_byte(8'hAA, 1'b1, 1'b1);
      offer_byte(8'h61, 1'b1, 1'b0);
      offer_byte(8'h62, 1'b1, 1'b0);
      offer_byte(8'h63, 1'b1, 1'b1);
      offer_byte(8'h01, 1'b1, 1'b0);
      offer_byte(8'h80, 1'b1, 1'b0);
      offer_byte(8'h5A, 1'b0, 1'b1);     // last without a byte
      offer_byte(8'h7F, 1'b1, 1'b0);
      offer_byte(8'h33, 1'b0, 1'b0);     // idle inside a key
      offer_byte(8'hFE, 1'b1, 1'b1);
      offer_byte(8'hFF, 1'b1, 1'b0);
      offer_byte(8'hFF, 1'b1, 1'b0);
      offer_byte(8'hFF, 1'b1, 1'b0);
      offer_byte(8'hFF, 1'b1, 1'b1);
      offer_byte(8'hFF, 1'b0, 1'b1);     // empty key with a junk byte
      drain_keys();

      // random phases, each under its own table size
      for (int p = 0; p < 7; p++) begin
         phase_num = p + 1;
         gaps_on   = (p % 3) != 1;
         write_table_size(size_plan[p]);
         goal = items_sent + 180;
         while (items_sent < goal) begin
            r   = $urandom_range(0, 31);
            len = (r == 0) ? 0 : (r < 4) ? $urandom_range(17, 48) : $urandom_range(1, 16);
            send_key(len);
         end
         drain_keys();
      end

      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
